// ----- rtl/core/rhc_pkg.sv -----
// Package for the RGB to HSV converter: the data word handed along the
// divider chain, sector codes and fixed-point constants.
// No dependencies.
`default_nettype none

package rhc_pkg;

    localparam int unsigned QuotBits = 16;

    // Hue step per sector (60 degrees times 64) and the full turn.
    localparam logic [14:0] HueStep = 15'd3840;
    localparam logic [14:0] HueWrap = 15'd23040;
    localparam logic [15:0] SatMax  = 16'hFFFF;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // Work carried by one pixel through the chain of divider cells.
    typedef struct packed {
        logic [7:0]  sat_rem;
        logic [7:0]  sat_div;
        logic [15:0] sat_q;
        logic [7:0]  hue_rem;
        logic [7:0]  hue_div;
        logic [15:0] hue_num;
        logic [15:0] hue_q;
        logic        neg;
        logic [1:0]  sector;
        logic        gray;
        logic        full;
        logic [7:0]  value;
    } t_div_state;

endpackage

`default_nettype wire

// ----- rtl/core/rhc_ifs.sv -----
// Stream interfaces of the RGB to HSV converter: the pixel channel and the
// result channel. Depends on nothing.
`default_nettype none

interface rhc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
    logic        valid;
    logic        ready;
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [7:0]  value_level;

    modport source (output valid, output hue, output saturation, output value_level,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input value_level,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_convert_unit.sv -----
// RGB to HSV converter, top level: front cell, chain of divider cells and
// output cell. Depends on rhc_pkg, rhc_ifs, rhc_front, rhc_div_cell, rhc_finish.
//
// Usage:
//   i_pix carries one 8-bit RGB pixel per transfer; o_hsv returns hue
//   (degrees times 64, 15 bits), saturation (16 fraction bits) and
//   value_level (largest channel) for every pixel, in order.
//   Each result passes through one front cell, sixteen divider cells (one
//   quotient bit of both divisions each) and one output cell before o_hsv.
//   Throughput is one pixel per cycle while the receiver does not stall;
//   each cell registers its work and hands it to its neighbor every cycle
//   in which that neighbor can take it.
//   Each cell has its own valid bit, so a stalled receiver holds the
//   result in the output cell while the cells behind it keep filling empty
//   slots; i_pix.ready drops only once every cell holds a pixel.
//   Reset (synchronous, active low) empties all cells; nothing else is
//   held, so no clearing is needed.
`default_nettype none

module rgb_to_hsv_convert_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhc_pix_if.sink     i_pix,
    rhc_hsv_if.source   o_hsv
);

    localparam int unsigned Cells = rhc_pkg::QuotBits;

    logic                valid [Cells+1];
    logic                ready [Cells+1];
    rhc_pkg::t_div_state state [Cells+1];

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_state (state[0])
    );

    for (genvar c = 0; c < Cells; c++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[c]),
            .o_ready (ready[c]),
            .i_state (state[c]),
            .o_valid (valid[c+1]),
            .i_ready (ready[c+1]),
            .o_state (state[c+1])
        );
    end

    rhc_finish u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (valid[Cells]),
        .o_ready       (ready[Cells]),
        .i_state       (state[Cells]),
        .o_valid       (o_hsv.valid),
        .i_ready       (o_hsv.ready),
        .o_hue         (o_hsv.hue),
        .o_saturation  (o_hsv.saturation),
        .o_value_level (o_hsv.value_level)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rhc_front.sv -----
// Front cell: finds max, min and sector of a pixel and loads both dividers.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_red,
    input  wire logic [7:0]        i_green,
    input  wire logic [7:0]        i_blue,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rhc_pkg::t_div_state    o_state
);

    logic                r_valid;
    rhc_pkg::t_div_state r_state;
    rhc_pkg::t_div_state n_state;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [7:0]  pa;
    logic [7:0]  pb;
    logic [7:0]  mag;
    logic [11:0] mag15;
    logic [1:0]  sector;

    always_comb begin
        // Red wins ties for the largest channel, then green.
        priority if (i_red >= i_green && i_red >= i_blue) begin
            mx     = i_red;
            sector = rhc_pkg::SECT_RED;
            pa     = i_green;
            pb     = i_blue;
        end else if (i_green >= i_blue) begin
            mx     = i_green;
            sector = rhc_pkg::SECT_GREEN;
            pa     = i_blue;
            pb     = i_red;
        end else begin
            mx     = i_blue;
            sector = rhc_pkg::SECT_BLUE;
            pa     = i_red;
            pb     = i_green;
        end

        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        delta = mx - mn;

        mag   = (pa >= pb) ? (pa - pb) : (pb - pa);
        mag15 = {mag, 4'b0000} - {4'b0000, mag};

        n_state.value   = mx;
        n_state.sector  = sector;
        n_state.gray    = (delta == 8'd0);
        n_state.full    = (mn == 8'd0) && (delta != 8'd0);
        n_state.neg     = (pa < pb);
        // Saturation divides delta * 2^16 by max; a full ratio is flagged instead.
        n_state.sat_rem = (mn == 8'd0) ? 8'd0 : delta;
        n_state.sat_div = mx;
        n_state.sat_q   = '0;
        // Hue divides 3840 * |n| = (15 * |n|) << 8 by delta; top 4 bits seed the remainder.
        n_state.hue_rem = {4'b0000, mag15[11:8]};
        n_state.hue_num = {mag15[7:0], 8'h00};
        n_state.hue_div = delta;
        n_state.hue_q   = '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- rtl/core/rhc_div_cell.sv -----
// One divider cell: a restoring step for the saturation and hue quotients.
// Depends on rhc_pkg.
`default_nettype none

module rhc_div_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire rhc_pkg::t_div_state  i_state,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output rhc_pkg::t_div_state       o_state
);

    logic                r_valid;
    rhc_pkg::t_div_state r_state;
    rhc_pkg::t_div_state n_state;

    logic [8:0] sat_t;
    logic [8:0] hue_t;
    logic       sat_ge;
    logic       hue_ge;
    logic [8:0] sat_d;
    logic [8:0] hue_d;

    always_comb begin
        n_state = i_state;

        sat_t  = {i_state.sat_rem, 1'b0};
        sat_ge = sat_t >= {1'b0, i_state.sat_div};
        sat_d  = sat_t - {1'b0, i_state.sat_div};
        n_state.sat_rem = sat_ge ? sat_d[7:0] : sat_t[7:0];
        n_state.sat_q   = {i_state.sat_q[14:0], sat_ge};

        // The next dividend bit shifts in from the top of hue_num.
        hue_t  = {i_state.hue_rem, i_state.hue_num[15]};
        hue_ge = hue_t >= {1'b0, i_state.hue_div};
        hue_d  = hue_t - {1'b0, i_state.hue_div};
        n_state.hue_rem = hue_ge ? hue_d[7:0] : hue_t[7:0];
        n_state.hue_num = {i_state.hue_num[14:0], 1'b0};
        n_state.hue_q   = {i_state.hue_q[14:0], hue_ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- rtl/core/rhc_finish.sv -----
// Output cell: applies sign, sector offset, wrap and saturation, and holds
// the result for the receiver. Depends on rhc_pkg.
`default_nettype none

module rhc_finish (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire rhc_pkg::t_div_state  i_state,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [14:0]               o_hue,
    output logic [15:0]               o_saturation,
    output logic [7:0]                o_value_level
);

    logic        r_valid;
    logic [14:0] r_hue;
    logic [15:0] r_sat;
    logic [7:0]  r_value;
    logic [14:0] n_hue;
    logic [15:0] n_sat;

    logic [14:0] base;
    logic [14:0] sub;

    always_comb begin
        unique case (i_state.sector)
            rhc_pkg::SECT_GREEN: base = {rhc_pkg::HueStep[13:0], 1'b0};
            rhc_pkg::SECT_BLUE:  base = {rhc_pkg::HueStep[12:0], 2'b00};
            default:             base = '0;
        endcase

        // Floor of a negative ratio takes one more step down when there is a remainder.
        sub = i_state.hue_q[14:0] + {14'd0, (i_state.hue_rem != 8'd0)};

        if (i_state.gray) begin
            n_hue = '0;
        end else if (!i_state.neg) begin
            n_hue = base + i_state.hue_q[14:0];
        end else if (base >= sub) begin
            n_hue = base - sub;
        end else begin
            n_hue = base + rhc_pkg::HueWrap - sub;
        end

        priority if (i_state.gray) begin
            n_sat = '0;
        end else if (i_state.full) begin
            n_sat = rhc_pkg::SatMax;
        end else begin
            n_sat = i_state.sat_q;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_value <= i_state.value;
        end
    end

    assign o_valid       = r_valid;
    assign o_hue         = r_hue;
    assign o_saturation  = r_sat;
    assign o_value_level = r_value;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for rgb_to_hsv_convert_unit: predicts hue, saturation
// and value for every pixel transfer and checks the results in order.
// Depends on rhc_pkg, rhc_ifs and the converter RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned StallLimit   = 2000;
    localparam int unsigned DrainCycles  = 40;
    localparam int unsigned RandomPixels = 1950;
    localparam int unsigned PhaseLength  = 120;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [7:0]  value_level;
    } t_hsv;

    logic i_clk;
    logic i_rst_n = 1'b0;

    rhc_pix_if pix_if ();
    rhc_hsv_if hsv_if ();

    t_pixel      pending_pixels[$];
    t_hsv        hsv_expected[$];
    int unsigned pixels_accepted = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;

    rgb_to_hsv_convert_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_hsv   (hsv_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_hsv rgb_to_hsv_predict(t_pixel px);
        int         r;
        int         g;
        int         b;
        int         mx;
        int         mn;
        int         delta;
        int         ratio;
        int         num;
        int         hue;
        logic [1:0] sector;
        t_hsv       res;
        r = px.red;
        g = px.green;
        b = px.blue;
        // Strict compares give red the win on ties, then green.
        mx = r;
        sector = rhc_pkg::SECT_RED;
        if (g > mx) begin
            mx = g;
            sector = rhc_pkg::SECT_GREEN;
        end
        if (b > mx) begin
            mx = b;
            sector = rhc_pkg::SECT_BLUE;
        end
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res.value_level = mx[7:0];
        // Black and gray pixels carry no hue and no saturation.
        if (delta == 0) begin
            res.hue = '0;
            res.saturation = '0;
            return res;
        end
        ratio = (delta * 65536) / mx;
        res.saturation = (ratio > int'(rhc_pkg::SatMax)) ? rhc_pkg::SatMax : ratio[15:0];
        case (sector)
            rhc_pkg::SECT_RED:   num = g - b;
            rhc_pkg::SECT_GREEN: num = 2 * delta + b - r;
            default:             num = 4 * delta + r - g;
        endcase
        num = num * int'(rhc_pkg::HueStep);
        // Floor division, rounding toward minus infinity.
        if (num >= 0) hue = num / delta;
        else hue = -((-num + delta - 1) / delta);
        if (hue < 0) hue = hue + int'(rhc_pkg::HueWrap);
        if (hue >= int'(rhc_pkg::HueWrap)) hue = hue - int'(rhc_pkg::HueWrap);
        res.hue = hue[14:0];
        return res;
    endfunction

    function automatic int unsigned traffic_phase();
        return (pixels_accepted / PhaseLength) % 4;
    endfunction

    function automatic bit sender_pauses();
        case (traffic_phase())
            1:       return $urandom_range(99) < 55;
            3:       return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (traffic_phase())
            2:       return $urandom_range(99) < 55;
            3:       return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] edge_level();
        case ($urandom_range(4))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            3:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel px;
        px.red = r;
        px.green = g;
        px.blue = b;
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    task automatic add_random_pixel();
        logic [7:0]  a;
        logic [7:0]  c;
        int unsigned pick;
        a = 8'($urandom_range(255));
        c = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 50) begin
            add_pixel(8'($urandom_range(255)), a, c);
        end else if (pick < 62) begin
            add_pixel(a, a, a);
        end else if (pick < 77) begin
            // Two channels tie, either on the maximum or elsewhere.
            case ($urandom_range(2))
                0:       add_pixel(a, a, c);
                1:       add_pixel(c, a, a);
                default: add_pixel(a, c, a);
            endcase
        end else if (pick < 88) begin
            // One channel at zero gives full saturation unless the pixel is black.
            case ($urandom_range(2))
                0:       add_pixel(8'd0, a, c);
                1:       add_pixel(a, 8'd0, c);
                default: add_pixel(a, c, 8'd0);
            endcase
        end else begin
            add_pixel(edge_level(), edge_level(), edge_level());
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender: a new pixel is offered only when the channel is free or the
    // previous transfer completes in this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pending_pixels.size() > 0 && !sender_pauses()) begin
                pix_if.valid <= 1'b1;
                pix_if.red   <= pending_pixels[0].red;
                pix_if.green <= pending_pixels[0].green;
                pix_if.blue  <= pending_pixels[0].blue;
                void'(pending_pixels.pop_front());
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) hsv_if.ready <= 1'b0;
        else hsv_if.ready <= !receiver_stalls();
    end

    always @(posedge i_clk) begin
        t_pixel px;
        t_hsv   want;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            px.red = pix_if.red;
            px.green = pix_if.green;
            px.blue = pix_if.blue;
            hsv_expected.insert(hsv_expected.size(), rgb_to_hsv_predict(px));
            pixels_accepted++;
            moved = 1'b1;
        end
        if (i_rst_n && hsv_if.valid && hsv_if.ready) begin
            moved = 1'b1;
            if (hsv_expected.size() == 0) begin
                // A result transfer arrived with no pixel pending.
                report_mismatch("pixels pending", 0, 1);
            end else begin
                want = hsv_expected.pop_front();
                if (hsv_if.hue !== want.hue)
                    report_mismatch("hue", hsv_if.hue, want.hue);
                if (hsv_if.saturation !== want.saturation)
                    report_mismatch("saturation", hsv_if.saturation, want.saturation);
                if (hsv_if.value_level !== want.value_level)
                    report_mismatch("value_level", hsv_if.value_level, want.value_level);
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= StallLimit);
        $display("Verification failed");
        $finish;
    end

    initial begin
        pix_if.valid = 1'b0;
        pix_if.red = '0;
        pix_if.green = '0;
        pix_if.blue = '0;
        hsv_if.ready = 1'b0;

        // Black, white, gray and the primaries and secondaries.
        add_pixel(8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_pixel(8'd1, 8'd1, 8'd1);
        add_pixel(8'd128, 8'd128, 8'd128);
        add_pixel(8'd255, 8'd0, 8'd0);
        add_pixel(8'd0, 8'd255, 8'd0);
        add_pixel(8'd0, 8'd0, 8'd255);
        add_pixel(8'd255, 8'd255, 8'd0);
        add_pixel(8'd0, 8'd255, 8'd255);
        add_pixel(8'd255, 8'd0, 8'd255);
        // Ties on the largest channel.
        add_pixel(8'd200, 8'd200, 8'd10);
        add_pixel(8'd10, 8'd200, 8'd200);
        add_pixel(8'd200, 8'd10, 8'd200);
        // Red largest with blue above green wraps the hue below zero.
        add_pixel(8'd255, 8'd0, 8'd1);
        add_pixel(8'd200, 8'd100, 8'd101);
        // Small deltas and single-step values.
        add_pixel(8'd1, 8'd0, 8'd0);
        add_pixel(8'd0, 8'd1, 8'd0);
        add_pixel(8'd0, 8'd0, 8'd1);
        add_pixel(8'd255, 8'd254, 8'd254);
        add_pixel(8'd254, 8'd255, 8'd254);
        add_pixel(8'd254, 8'd254, 8'd255);
        add_pixel(8'd170, 8'd85, 8'd42);
        add_pixel(8'd3, 8'd2, 8'd1);
        repeat (RandomPixels) add_random_pixel();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() > 0 || pix_if.valid) @(posedge i_clk);
        while (hsv_expected.size() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- rgb_to_hsv_convert_unit.f -----
rtl/core/rhc_pkg.sv
rtl/core/rhc_ifs.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div_cell.sv
rtl/core/rhc_finish.sv
rtl/core/rgb_to_hsv_convert_unit.sv
dv/tb_top.sv
